FILE: rtl/coordinate_text_parser_unit_macros.svh
// assertion macros used by the coordinate text parser checker
`ifndef COORDINATE_TEXT_PARSER_UNIT_MACROS_SVH
`define COORDINATE_TEXT_PARSER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CTP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("coordinate parser check failed");

// next-cycle implication, checked outside reset
`define CTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("coordinate parser check failed");

`endif

FILE: rtl/ctp_pkg.sv
// types, character codes and weights for the coordinate text parser
package ctp_pkg;

    // parse phase
    typedef enum logic [1:0] {
        PH_SPACES = 2'd0,
        PH_SIGN   = 2'd1,
        PH_BODY   = 2'd2
    } ctp_phase_t;

    // running parse state
    typedef struct packed {
        ctp_phase_t  phase;
        logic [31:0] whole_degrees;
        logic [14:0] fraction_sum;
        logic [2:0]  fraction_count;
        logic        seen_dot;
        logic        is_negative;
    } ctp_state_t;

    localparam logic [7:0] CHR_END   = 8'h00;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_PLUS  = 8'h2b;
    localparam logic [7:0] CHR_MINUS = 8'h2d;
    localparam logic [7:0] CHR_DOT   = 8'h2e;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_UP_A  = 8'h41;
    localparam logic [7:0] CHR_UP_Z  = 8'h5a;
    localparam logic [7:0] CHR_CASE  = 8'h20;
    localparam logic [7:0] CHR_LO_E  = 8'h65;
    localparam logic [7:0] CHR_LO_N  = 8'h6e;
    localparam logic [7:0] CHR_LO_S  = 8'h73;
    localparam logic [7:0] CHR_LO_W  = 8'h77;

    // units of 1/30000 degree per whole degree
    localparam logic [14:0] DEG_SCALE = 15'd30000;

    // weight of each fraction digit position
    function automatic logic [11:0] frac_weight(input logic [1:0] pos);
        logic [11:0] w;
        case (pos)
            2'd0:    w = 12'd3000;
            2'd1:    w = 12'd300;
            2'd2:    w = 12'd30;
            default: w = 12'd3;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/ctp_scanner.sv
// per-character parse state update and state registers
module ctp_scanner #(
    parameter int FRACTION_DIGITS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          char_code,
    output ctp_pkg::ctp_state_t state
);

    localparam logic [2:0] FRAC_LIMIT = 3'(FRACTION_DIGITS);

    ctp_pkg::ctp_state_t state_reg;
    ctp_pkg::ctp_state_t state_next;

    logic [7:0]  lower;
    logic        is_sw;
    logic        is_ne;
    logic        is_sign;
    logic        is_digit;
    logic [3:0]  digit;
    logic        in_spaces;
    logic        in_sign;
    logic        go_sign;
    logic        go_body;
    logic [26:0] frac_add;

    // character classes
    always_comb
    begin
        lower    = (char_code inside {[ctp_pkg::CHR_UP_A:ctp_pkg::CHR_UP_Z]})
                   ? char_code + ctp_pkg::CHR_CASE : char_code;
        is_sw    = (lower == ctp_pkg::CHR_LO_S) || (lower == ctp_pkg::CHR_LO_W);
        is_ne    = (lower == ctp_pkg::CHR_LO_N) || (lower == ctp_pkg::CHR_LO_E);
        is_sign  = (char_code == ctp_pkg::CHR_PLUS) || (char_code == ctp_pkg::CHR_MINUS);
        is_digit = char_code inside {[ctp_pkg::CHR_ZERO:ctp_pkg::CHR_NINE]};
        digit    = 4'(char_code - ctp_pkg::CHR_ZERO);
    end

    // which phase handles this character (a miss falls through)
    always_comb
    begin
        in_spaces = 1'b0;
        in_sign   = 1'b0;
        case (state_reg.phase)
            ctp_pkg::PH_SPACES: in_spaces = 1'b1;
            ctp_pkg::PH_SIGN:   in_sign   = 1'b1;
            default:            in_sign   = 1'b0;
        endcase
        go_sign = in_sign || (in_spaces && (char_code != ctp_pkg::CHR_SPACE)
                  && !is_sw && !is_ne);
        go_body = (!in_spaces && !in_sign) || (go_sign && !is_sign);
        frac_add = 27'(digit * ctp_pkg::frac_weight(state_reg.fraction_count[1:0]));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (char_code == ctp_pkg::CHR_END)
        begin
            state_next.phase          = ctp_pkg::PH_SPACES;
            state_next.whole_degrees  = '0;
            state_next.fraction_sum   = '0;
            state_next.fraction_count = '0;
            state_next.seen_dot       = 1'b0;
            state_next.is_negative    = 1'b0;
        end
        else
        begin
            // leading spaces and hemisphere letter
            if (in_spaces && (char_code != ctp_pkg::CHR_SPACE))
            begin
                state_next.phase = ctp_pkg::PH_SIGN;
                if (is_sw)
                begin
                    state_next.is_negative = 1'b1;
                end
            end
            // optional sign
            if (go_sign)
            begin
                state_next.phase = ctp_pkg::PH_BODY;
                if (is_sign)
                begin
                    state_next.is_negative = (char_code == ctp_pkg::CHR_MINUS);
                end
            end
            // number body
            if (go_body)
            begin
                if (char_code == ctp_pkg::CHR_DOT)
                begin
                    state_next.seen_dot = 1'b1;
                end
                else if (is_digit)
                begin
                    if (!state_reg.seen_dot)
                    begin
                        state_next.whole_degrees = (state_reg.whole_degrees << 3)
                            + (state_reg.whole_degrees << 1) + 32'(digit);
                    end
                    else if (state_reg.fraction_count < FRAC_LIMIT)
                    begin
                        state_next.fraction_sum   = 15'(state_reg.fraction_sum + frac_add);
                        state_next.fraction_count = state_reg.fraction_count + 3'd1;
                    end
                end
                else if (is_sw)
                begin
                    state_next.is_negative = 1'b1;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase          <= ctp_pkg::PH_SPACES;
            state_reg.whole_degrees  <= '0;
            state_reg.fraction_sum   <= '0;
            state_reg.fraction_count <= '0;
            state_reg.seen_dot       <= 1'b0;
            state_reg.is_negative    <= 1'b0;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

FILE: rtl/ctp_scaler.sv
// turns degrees and fraction into a signed 1/30000 degree value
module ctp_scaler (
    input  ctp_pkg::ctp_state_t state,
    output logic signed [31:0]  coordinate
);

    logic [31:0] scaled;
    logic [31:0] magnitude;

    // degrees * 30000 + fraction, wrapping, then optional negate
    always_comb
    begin
        scaled     = 32'(state.whole_degrees * 32'(ctp_pkg::DEG_SCALE));
        magnitude  = scaled + 32'(state.fraction_sum);
        coordinate = state.is_negative ? signed'(32'(0) - magnitude) : signed'(magnitude);
    end

endmodule

FILE: rtl/coordinate_text_parser_unit.sv
// coordinate text parser top level: input register, parser, result register
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------
//  in      | in_valid  | in_stall  | char_code [7:0]
//  out     | out_valid | out_stall | coordinate [31:0] signed
//
// when not stalled, one character per cycle, each parsed the cycle after it is taken
// a zero byte puts its coordinate in the result register at the edge after it
// is taken when the result slot is free, the parse state is cleared at that edge
// reset clears the parse state and both valid flags
// a held zero byte waits only while a result sits stalled; other characters
// keep flowing into the parse state while the result waits
module coordinate_text_parser_unit #(
    parameter int FRACTION_DIGITS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         char_code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] coordinate
);

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [7:0]         char_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [31:0] coordinate_reg;

    logic                accept;
    logic                advance;
    logic                step;
    logic                emit;
    ctp_pkg::ctp_state_t state;
    logic signed [31:0]  coord_calc;

    // handshake control
    always_comb
    begin
        advance  = (char_reg != ctp_pkg::CHR_END) || !out_valid_reg || !out_stall;
        in_stall = in_valid_reg && !advance;
        accept   = in_valid && !in_stall;
        step     = in_valid_reg && advance;
        emit     = step && (char_reg == ctp_pkg::CHR_END);
        in_valid_next  = accept ? 1'b1 : (step ? 1'b0 : in_valid_reg);
        out_valid_next = emit || (out_valid_reg && out_stall);
    end

    // parse state
    ctp_scanner #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .char_code (char_reg),
        .state     (state)
    );

    // final scaling
    ctp_scaler u_scaler (
        .state      (state),
        .coordinate (coord_calc)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_code;
        end
        if (emit)
        begin
            coordinate_reg <= coord_calc;
        end
    end

    assign out_valid  = out_valid_reg;
    assign coordinate = coordinate_reg;

endmodule

FILE: rtl/ctp_checker.sv
// port-level checks for the coordinate text parser, bound to the top level
`include "coordinate_text_parser_unit_macros.svh"

module ctp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] coordinate
);

    // a stalled result holds
    `CTP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(coordinate))

    // a result leaves only when taken
    `CTP_ASSERT_NOW(a_out_drop, $fell(out_valid), $past(!out_stall))

    // input stalls only behind a stalled result
    `CTP_ASSERT_NOW(a_stall_cause, !out_valid || !out_stall, !in_stall)

    // a stall means an item was taken earlier and is still held
    `CTP_ASSERT_NOW(a_stall_held, in_stall, $past(in_valid && !in_stall) || $past(in_stall))

endmodule

bind coordinate_text_parser_unit ctp_checker u_ctp_checker (.*);

FILE: tb/tb_coordinate_text_parser_unit.sv
// testbench for the coordinate text parser: queued text driver, checking monitor, own parse model
`timescale 1ns / 1ps

module tb_coordinate_text_parser_unit;

    localparam int FRACTION_DIGITS = 4;
    localparam int IDLE_PCT        = 37;
    localparam int TARGET_CHARS    = 900;

    // one queued character, optionally held until all coordinates are in
    typedef struct packed {
        logic       drain_first;
        logic [7:0] ch;
    } text_byte_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [7:0]         char_code = 8'd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] coordinate;

    text_byte_t          text_bytes[$];
    logic signed [31:0]  want_coords[$];
    ctp_pkg::ctp_state_t parse_st   = '0;
    logic                next_drain = 1'b0;
    logic                in_taken   = 1'b0;
    int                  cyc_cnt    = 0;
    int                  char_cnt   = 0;
    int                  coord_cnt  = 0;
    int                  neg_cnt    = 0;
    int                  fail_cnt   = 0;

    // no idling on either side for a while
    wire calm = (cyc_cnt >= 600) && (cyc_cnt < 1100);

    coordinate_text_parser_unit #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .coordinate (coordinate)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= ctp_pkg::CHR_UP_A && c <= ctp_pkg::CHR_UP_Z)
            return c + ctp_pkg::CHR_CASE;
        return c;
    endfunction

    // advance the parse model by one character, queue a coordinate on end of text
    task automatic parse_char(input logic [7:0] c);
        logic [7:0]  lc;
        logic [31:0] sum;
        logic [31:0] d;
        logic [31:0] w;
        logic        pass_on;
        lc      = fold_case(c);
        pass_on = 1'b1;
        if (c == ctp_pkg::CHR_END)
        begin
            sum = parse_st.whole_degrees * 32'(ctp_pkg::DEG_SCALE)
                  + 32'(parse_st.fraction_sum);
            if (parse_st.is_negative)
                sum = -sum;
            want_coords.push_back(sum);
            parse_st = '0;
            pass_on  = 1'b0;
        end
        // leading spaces, then an optional compass letter
        if (pass_on && parse_st.phase == ctp_pkg::PH_SPACES)
        begin
            if (c == ctp_pkg::CHR_SPACE)
                pass_on = 1'b0;
            else
            begin
                parse_st.phase = ctp_pkg::PH_SIGN;
                if (lc == ctp_pkg::CHR_LO_S || lc == ctp_pkg::CHR_LO_W)
                begin
                    parse_st.is_negative = 1'b1;
                    pass_on = 1'b0;
                end
                else if (lc == ctp_pkg::CHR_LO_N || lc == ctp_pkg::CHR_LO_E)
                    pass_on = 1'b0;
            end
        end
        // optional sign
        if (pass_on && parse_st.phase == ctp_pkg::PH_SIGN)
        begin
            parse_st.phase = ctp_pkg::PH_BODY;
            if (c == ctp_pkg::CHR_PLUS || c == ctp_pkg::CHR_MINUS)
            begin
                parse_st.is_negative = (c == ctp_pkg::CHR_MINUS);
                pass_on = 1'b0;
            end
        end
        // body: degrees, dot, weighted fraction digits, late hemisphere letter
        if (pass_on)
        begin
            if (c == ctp_pkg::CHR_DOT)
                parse_st.seen_dot = 1'b1;
            else if (c >= ctp_pkg::CHR_ZERO && c <= ctp_pkg::CHR_NINE)
            begin
                d = 32'(c - ctp_pkg::CHR_ZERO);
                if (!parse_st.seen_dot)
                    parse_st.whole_degrees = parse_st.whole_degrees * 32'd10 + d;
                else if (parse_st.fraction_count < FRACTION_DIGITS
                         && parse_st.fraction_count < 4)
                begin
                    case (parse_st.fraction_count)
                        3'd0:    w = 32'd3000;
                        3'd1:    w = 32'd300;
                        3'd2:    w = 32'd30;
                        default: w = 32'd3;
                    endcase
                    parse_st.fraction_sum   = 15'(32'(parse_st.fraction_sum) + d * w);
                    parse_st.fraction_count = parse_st.fraction_count + 3'd1;
                end
            end
            else if (lc == ctp_pkg::CHR_LO_S || lc == ctp_pkg::CHR_LO_W)
                parse_st.is_negative = 1'b1;
        end
    endtask

    task automatic add_char(input logic [7:0] c);
        text_bytes.push_back('{drain_first: next_drain, ch: c});
        next_drain = 1'b0;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
        add_char(ctp_pkg::CHR_END);
    endtask

    // mostly well-formed coordinates with random content, some pure noise
    task automatic make_text();
        string letters = "NnEeSsWw";
        string tails   = "sSwWnE+-";
        int    n;
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 12))
                add_char(8'($urandom_range(1, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 3))
                add_char(ctp_pkg::CHR_SPACE);
            if ($urandom_range(4) != 0)
                add_char(letters[$urandom_range(7)]);
            case ($urandom_range(2))
                1:       add_char(ctp_pkg::CHR_PLUS);
                2:       add_char(ctp_pkg::CHR_MINUS);
                default: ;
            endcase
            n = ($urandom_range(19) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 3);
            repeat (n)
                add_char(ctp_pkg::CHR_ZERO + 8'($urandom_range(9)));
            if ($urandom_range(3) != 0)
            begin
                add_char(ctp_pkg::CHR_DOT);
                repeat ($urandom_range(0, 6))
                    add_char(ctp_pkg::CHR_ZERO + 8'($urandom_range(9)));
                if ($urandom_range(9) == 0)
                    add_char(ctp_pkg::CHR_DOT);
            end
            if ($urandom_range(3) == 0)
                add_char(tails[$urandom_range(7)]);
            if ($urandom_range(7) == 0)
                add_char(8'($urandom_range(1, 255)));
        end
        add_char(ctp_pkg::CHR_END);
    endtask

    // driver: present queued characters, hold each until taken
    always @(negedge clk)
    begin : drive_chars
        text_byte_t nxt;
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (text_bytes.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)
                    && !(text_bytes[0].drain_first && want_coords.size() != 0))
                begin
                    nxt       = text_bytes.pop_front();
                    in_valid  <= 1'b1;
                    char_code <= nxt.ch;
                end
                else
                begin
                    in_valid  <= 1'b0;
                    char_code <= 8'($urandom_range(255));
                end
            end
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // monitor: check coordinates taken, feed characters taken to the model
    always @(posedge clk)
    begin : watch_ports
        logic signed [31:0] want;
        if (rst_n)
        begin
            cyc_cnt  <= cyc_cnt + 1;
            in_taken <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (want_coords.size() == 0)
                begin
                    $error("coordinate: none expected, got %0d", coordinate);
                    fail_cnt++;
                end
                else
                begin
                    want = want_coords.pop_front();
                    coord_cnt++;
                    if (want < 0)
                        neg_cnt++;
                    if (coordinate !== want)
                    begin
                        $error("coordinate: expected %0d, got %0d", want, coordinate);
                        fail_cnt++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                char_cnt++;
                parse_char(char_code);
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        // empty text
        add_text("");
        // a space, lowercase letter, plus sign, extra fraction digits, second dot
        add_text(" e+1.23456.7");
        // degree product wraps onto the most negative value, negation keeps it
        add_text("S134217728");
        // sign with no letter, high byte ignored, sign and letter in the body
        add_text("-9\377.-w");
        next_drain = 1'b1;
        for (int t = 0; text_bytes.size() < TARGET_CHARS + 32; t++)
        begin
            if (t % 40 == 39)
                next_drain = 1'b1;
            make_text();
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (text_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (want_coords.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("run: %0d characters parsed, %0d coordinates checked, %0d of them negative",
                 char_cnt, coord_cnt, neg_cnt);
        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial
    begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
